FILE: src/assert_macros.svh
// Assertion macros used by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rsig_pkg.sv
// Package: widths, codes and control types of the radar scope intensity generator.
`timescale 1ns / 1ps
package rsig_pkg;

	localparam int MAX_TARGETS    = 64;
	localparam int SLOT_W         = $clog2(MAX_TARGETS);
	localparam int DAC_RESOLUTION = 1024;
	localparam int DAC_W          = $clog2(DAC_RESOLUTION);
	localparam int DAC_HALF       = DAC_RESOLUTION / 2;
	localparam int BLANK_LIMIT    = 2;
	localparam int TRACE_THRESH   = DAC_HALF + BLANK_LIMIT;
	localparam int SCALE_BITS     = 6;

	localparam int INDEX_W   = 10;
	localparam int POS_W     = 10;
	localparam int TSLOT_W   = 6;
	localparam int OFFSET_W  = 16;
	localparam int FRAC_BITS = 4;
	localparam int QPOS_W    = POS_W + FRAC_BITS;
	localparam int DX_W      = OFFSET_W + 1;
	localparam int SQ_W      = 2 * DX_W - 2;

	localparam int LEVEL_W  = 10;
	localparam int RADIUS_W = 32;
	localparam int STEP_W   = 5;
	localparam int WORD_W   = 16;
	localparam int CLASS_W  = 2;

	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [3:0] DAC_PREFIX = 4'hF;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [CLASS_W-1:0] CLS_BLANK = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_DIM   = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_SCALE = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_BLIP  = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_BLANK  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIM    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SCALE  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BLIP   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STEP   = 3'd5;

	// drain counter value at which the hit flag is final after the last slot read
	localparam logic [SLOT_W-1:0] DRAIN_LAST = SLOT_W'(3);

	typedef struct packed {
		logic [LEVEL_W-1:0]  blank_level;
		logic [LEVEL_W-1:0]  dim_level;
		logic [LEVEL_W-1:0]  scale_level;
		logic [LEVEL_W-1:0]  blip_level;
		logic [RADIUS_W-1:0] blip_radius_sq;
		logic [STEP_W-1:0]   trace_step;
	} rsig_cfg_t;

	typedef struct packed {
		logic              capture;
		logic              load_slot;
		logic              clear_hit;
		logic              scan;
		logic [SLOT_W-1:0] slot;
		logic              out_load;
	} rsig_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} rsig_sts_t;

endpackage

FILE: src/rsig_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface rsig_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic [rsig_pkg::INDEX_W-1:0]         trace_index;
	logic [rsig_pkg::POS_W-1:0]           x_position;
	logic [rsig_pkg::POS_W-1:0]           y_position;
	logic [rsig_pkg::TSLOT_W-1:0]         target_slot;
	logic                                 target_active;
	logic signed [rsig_pkg::OFFSET_W-1:0] target_x_offset;
	logic signed [rsig_pkg::OFFSET_W-1:0] target_y_offset;

	modport source (
		output valid, operation, trace_index, x_position, y_position,
		output target_slot, target_active, target_x_offset, target_y_offset,
		input  ready
	);
	modport sink (
		input  valid, operation, trace_index, x_position, y_position,
		input  target_slot, target_active, target_x_offset, target_y_offset,
		output ready
	);
endinterface

interface rsig_out_if;
	logic                         valid;
	logic                         ready;
	logic [rsig_pkg::WORD_W-1:0]  dac_word;
	logic [rsig_pkg::CLASS_W-1:0] point_class;

	modport source (output valid, dac_word, point_class, input ready);
	modport sink (input valid, dac_word, point_class, output ready);
endinterface

FILE: src/rsig_cfg.sv
// Configuration register file behind the APB port.
`timescale 1ns / 1ps
module rsig_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rsig_pkg::PADDR_W-1:0]  paddr,
	input  logic [rsig_pkg::PDATA_W-1:0]  pwdata,
	output logic [rsig_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output rsig_pkg::rsig_cfg_t           cfg
);

	rsig_pkg::rsig_cfg_t                   cfg_q;
	logic [rsig_pkg::REG_IDX_W-1:0]        reg_idx;
	logic                                  wr_en;

	assign reg_idx = paddr[rsig_pkg::PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blank_level    <= rsig_pkg::LEVEL_W'(1023);
			cfg_q.dim_level      <= rsig_pkg::LEVEL_W'(512);
			cfg_q.scale_level    <= rsig_pkg::LEVEL_W'(470);
			cfg_q.blip_level     <= rsig_pkg::LEVEL_W'(0);
			cfg_q.blip_radius_sq <= rsig_pkg::RADIUS_W'(5138);
			cfg_q.trace_step     <= rsig_pkg::STEP_W'(4);
		end else if (wr_en) begin
			unique case (reg_idx)
				rsig_pkg::REG_BLANK: begin
					cfg_q.blank_level <= pwdata[rsig_pkg::LEVEL_W-1:0];
				end
				rsig_pkg::REG_DIM: begin
					cfg_q.dim_level <= pwdata[rsig_pkg::LEVEL_W-1:0];
				end
				rsig_pkg::REG_SCALE: begin
					cfg_q.scale_level <= pwdata[rsig_pkg::LEVEL_W-1:0];
				end
				rsig_pkg::REG_BLIP: begin
					cfg_q.blip_level <= pwdata[rsig_pkg::LEVEL_W-1:0];
				end
				rsig_pkg::REG_RADIUS: begin
					cfg_q.blip_radius_sq <= pwdata[rsig_pkg::RADIUS_W-1:0];
				end
				rsig_pkg::REG_STEP: begin
					cfg_q.trace_step <= pwdata[rsig_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rsig_pkg::REG_BLANK:  prdata = rsig_pkg::PDATA_W'(cfg_q.blank_level);
			rsig_pkg::REG_DIM:    prdata = rsig_pkg::PDATA_W'(cfg_q.dim_level);
			rsig_pkg::REG_SCALE:  prdata = rsig_pkg::PDATA_W'(cfg_q.scale_level);
			rsig_pkg::REG_BLIP:   prdata = rsig_pkg::PDATA_W'(cfg_q.blip_level);
			rsig_pkg::REG_RADIUS: prdata = rsig_pkg::PDATA_W'(cfg_q.blip_radius_sq);
			rsig_pkg::REG_STEP:   prdata = rsig_pkg::PDATA_W'(cfg_q.trace_step);
			default:              prdata = '0;
		endcase
	end

endmodule

FILE: src/rsig_ctrl.sv
// Controller: accepts requests, sequences the slot scan and the result load.
`timescale 1ns / 1ps
module rsig_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_operation,
	output logic                 in_ready,
	input  rsig_pkg::rsig_sts_t  sts,
	output rsig_pkg::rsig_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                    state_q;
	logic [rsig_pkg::SLOT_W-1:0]   cnt_q;
	logic                          accept;
	logic                          scan_last;
	logic                          drain_last;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid & in_ready;
	assign scan_last  = (cnt_q == rsig_pkg::SLOT_W'(rsig_pkg::MAX_TARGETS - 1));
	assign drain_last = (cnt_q == rsig_pkg::DRAIN_LAST);

	always_comb begin
		cmd.capture   = accept & (in_operation == rsig_pkg::OP_DRAW);
		cmd.load_slot = accept & (in_operation == rsig_pkg::OP_LOAD);
		cmd.clear_hit = cmd.capture;
		cmd.scan      = (state_q == ST_SCAN);
		cmd.slot      = cnt_q;
		// hold the finished result while the output register is occupied and not being taken
		cmd.out_load  = (state_q == ST_DRAIN) & drain_last & ~sts.out_blocked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!drain_last) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/rsig_dpath.sv
// Datapath: target table, distance pipeline, hit flag and result register.
`timescale 1ns / 1ps
module rsig_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rsig_pkg::rsig_cmd_t                  cmd,
	output rsig_pkg::rsig_sts_t                  sts,
	input  rsig_pkg::rsig_cfg_t                  cfg,
	input  logic [rsig_pkg::INDEX_W-1:0]         trace_index,
	input  logic [rsig_pkg::POS_W-1:0]           x_position,
	input  logic [rsig_pkg::POS_W-1:0]           y_position,
	input  logic [rsig_pkg::TSLOT_W-1:0]         target_slot,
	input  logic                                 target_active,
	input  logic signed [rsig_pkg::OFFSET_W-1:0] target_x_offset,
	input  logic signed [rsig_pkg::OFFSET_W-1:0] target_y_offset,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rsig_pkg::WORD_W-1:0]          dac_word,
	output logic [rsig_pkg::CLASS_W-1:0]         point_class
);

	localparam int OW = rsig_pkg::OFFSET_W;

	logic [2*OW-1:0]                      slot_mem [rsig_pkg::MAX_TARGETS];
	logic [rsig_pkg::MAX_TARGETS-1:0]     active_q;
	logic                                 slot_ok;
	logic [rsig_pkg::SLOT_W-1:0]          wr_addr;

	logic [rsig_pkg::DAC_W-1:0]           trace_q;
	logic signed [rsig_pkg::QPOS_W-1:0]   qx_q;
	logic signed [rsig_pkg::QPOS_W-1:0]   qy_q;

	logic [2*OW-1:0]                      rdata_s1;
	logic                                 v_s1;
	logic signed [OW-1:0]                 rd_xoff;
	logic signed [OW-1:0]                 rd_yoff;
	logic signed [rsig_pkg::DX_W-1:0]     dx_s2;
	logic signed [rsig_pkg::DX_W-1:0]     dy_s2;
	logic                                 v_s2;
	logic [rsig_pkg::SQ_W-1:0]            sqx_s3;
	logic [rsig_pkg::SQ_W-1:0]            sqy_s3;
	logic                                 v_s3;
	logic [rsig_pkg::SQ_W:0]              dist_sum;
	logic                                 hit_q;

	logic                                 blank;
	logic                                 scale;
	logic [rsig_pkg::LEVEL_W-1:0]         level;
	logic [rsig_pkg::CLASS_W-1:0]         cls;
	logic                                 out_valid_q;
	logic [rsig_pkg::WORD_W-1:0]          dac_word_q;
	logic [rsig_pkg::CLASS_W-1:0]         point_class_q;

	assign slot_ok = ({1'b0, target_slot} <
		(rsig_pkg::TSLOT_W + 1)'(rsig_pkg::MAX_TARGETS));
	assign wr_addr = target_slot[rsig_pkg::SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_slot && slot_ok) begin
			slot_mem[wr_addr] <= {target_x_offset, target_y_offset};
		end
		rdata_s1 <= slot_mem[cmd.slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.load_slot && slot_ok) begin
			active_q[wr_addr] <= target_active;
		end
	end

	// latch the point: trace position modulo the DAC range, centred Q10.4 X/Y
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			trace_q <= rsig_pkg::DAC_W'(trace_index * cfg.trace_step);
			qx_q    <= {~x_position[rsig_pkg::POS_W-1], x_position[rsig_pkg::POS_W-2:0],
				rsig_pkg::FRAC_BITS'(0)};
			qy_q    <= {~y_position[rsig_pkg::POS_W-1], y_position[rsig_pkg::POS_W-2:0],
				rsig_pkg::FRAC_BITS'(0)};
		end
	end

	assign rd_xoff = rdata_s1[2*OW-1:OW];
	assign rd_yoff = rdata_s1[OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan & active_q[cmd.slot];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= rsig_pkg::DX_W'(qx_q) + rsig_pkg::DX_W'(rd_xoff);
		dy_s2  <= rsig_pkg::DX_W'(qy_q) - rsig_pkg::DX_W'(rd_yoff);
		sqx_s3 <= rsig_pkg::SQ_W'(dx_s2 * dx_s2);
		sqy_s3 <= rsig_pkg::SQ_W'(dy_s2 * dy_s2);
	end

	assign dist_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.clear_hit) begin
			hit_q <= 1'b0;
		end else if (v_s3 && (dist_sum < {1'b0, cfg.blip_radius_sq})) begin
			hit_q <= 1'b1;
		end
	end

	assign blank = (trace_q <= rsig_pkg::DAC_W'(rsig_pkg::TRACE_THRESH));
	assign scale = (trace_q[rsig_pkg::SCALE_BITS-1:0] == '0);

	always_comb begin
		if (blank) begin
			level = cfg.blank_level;
			cls   = rsig_pkg::CLS_BLANK;
		end else if (hit_q) begin
			level = cfg.blip_level;
			cls   = rsig_pkg::CLS_BLIP;
		end else if (scale) begin
			level = cfg.scale_level;
			cls   = rsig_pkg::CLS_SCALE;
		end else begin
			level = cfg.dim_level;
			cls   = rsig_pkg::CLS_DIM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dac_word_q    <= {rsig_pkg::DAC_PREFIX, level, 2'b00};
			point_class_q <= cls;
		end
	end

	assign sts.out_blocked = out_valid_q & ~out_ready;
	assign out_valid       = out_valid_q;
	assign dac_word        = dac_word_q;
	assign point_class     = point_class_q;

endmodule

FILE: src/radar_scope_intensity_generator_unit.sv
// Channel      Direction  Handshake      Contents
// cmd          in         valid/ready    draw point or target slot load
// res          out        valid/ready    DAC intensity word and point class
// APB          in/out     psel/penable   six configuration registers
//
// A load is written to the target table on acceptance. A draw is captured, reads
// the target table once per slot (64), passes the distance pipeline and waits while
// the output register is blocked. A new request is taken once the result is in the
// output register, which holds it until the sink takes it. Reset clears the active
// flags of all slots at once; no clearing pass runs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module radar_scope_intensity_generator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	rsig_in_if.sink                       cmd,
	rsig_out_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rsig_pkg::PADDR_W-1:0]  paddr,
	input  logic [rsig_pkg::PDATA_W-1:0]  pwdata,
	output logic [rsig_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	rsig_pkg::rsig_cfg_t cfg;
	rsig_pkg::rsig_cmd_t dp_cmd;
	rsig_pkg::rsig_sts_t dp_sts;

	rsig_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rsig_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cmd.valid),
		.in_operation (cmd.operation),
		.in_ready     (cmd.ready),
		.sts          (dp_sts),
		.cmd          (dp_cmd)
	);

	rsig_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.sts             (dp_sts),
		.cfg             (cfg),
		.trace_index     (cmd.trace_index),
		.x_position      (cmd.x_position),
		.y_position      (cmd.y_position),
		.target_slot     (cmd.target_slot),
		.target_active   (cmd.target_active),
		.target_x_offset (cmd.target_x_offset),
		.target_y_offset (cmd.target_y_offset),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.dac_word        (res.dac_word),
		.point_class     (res.point_class)
	);

	`ASSERT_IMPLIES(a_no_scan_when_ready, clk, arst_n, cmd.ready, !dp_cmd.scan, "scan while accepting")
	`ASSERT_NEXT(a_scan_blocks_request, clk, arst_n, dp_cmd.scan, !cmd.ready, "request taken mid-scan")
	`ASSERT_IMPLIES(a_result_from_load, clk, arst_n, $rose(res.valid), $past(dp_cmd.out_load), "result without load")

endmodule
